// ----- rtl/gwtg_pkg.sv -----
package gwtg_pkg;

    localparam int TAPS_DEFAULT = 8;

    localparam int TAP_W    = 6;
    localparam int SIGMA_W  = 16;
    localparam int WEIGHT_W = 16;
    localparam int RAW_W    = 32;
    localparam int TOTAL_W  = 40;
    localparam int FRAC_W   = 16;
    localparam int NINT_W   = 5;
    localparam int XX_W     = 12;
    localparam int V_W      = 31;
    localparam int K_W      = 4;

    // The iterative divider produces up to DIV_Q_W quotient bits.
    localparam int DIV_Q_W   = 21;
    localparam int DIV_CNT_W = 5;

    localparam logic [DIV_CNT_W-1:0] A_DIV_ITERS  = 5'd21;
    localparam logic [DIV_CNT_W-1:0] N_DIV_ITERS  = 5'd17;
    localparam logic [K_W-1:0]       HORNER_TERMS = 4'd12;

    localparam logic [RAW_W-1:0] ONE_Q31    = 32'h8000_0000;
    localparam logic [RAW_W-1:0] EXP_M1_Q31 = 32'd790015084;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REJECT,
        ST_TAP_START,
        ST_ADIV,
        ST_H_MUL,
        ST_H_RCP,
        ST_H_FIX,
        ST_E_MUL,
        ST_STORE,
        ST_N_READ,
        ST_N_START,
        ST_N_DIV,
        ST_N_OUT
    } gwtg_state_t;

    typedef struct packed {
        logic             load_sigma;
        logic             a_start;
        logic             a_take;
        logic             h_mul;
        logic             h_rcp;
        logic             h_fix;
        logic             e_mul;
        logic             store;
        logic             mem_rd;
        logic             n_start;
        logic             out_tap;
        logic             out_rej;
        logic [TAP_W-1:0] tap;
        logic [K_W-1:0]   k;
    } gwtg_cmd_t;

    typedef struct packed {
        logic sigma_zero;
        logic a_big;
        logic div_done;
        logic n_zero;
        logic out_free;
    } gwtg_status_t;

    // floor((2^32 - 1) / k); the product with a value below 2^31 undershoots
    // the true quotient by at most one.
    function automatic logic [RAW_W-1:0] recip_q32(input logic [K_W-1:0] k);
        logic [RAW_W-1:0] r;
        case (k)
            4'd1:    r = 32'hFFFF_FFFF;
            4'd2:    r = 32'h7FFF_FFFF;
            4'd3:    r = 32'h5555_5555;
            4'd4:    r = 32'h3FFF_FFFF;
            4'd5:    r = 32'h3333_3333;
            4'd6:    r = 32'h2AAA_AAAA;
            4'd7:    r = 32'h2492_4924;
            4'd8:    r = 32'h1FFF_FFFF;
            4'd9:    r = 32'h1C71_C71C;
            4'd10:   r = 32'h1999_9999;
            4'd11:   r = 32'h1745_D174;
            4'd12:   r = 32'h1555_5555;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/gwtg_div.sv -----
module gwtg_div
    import gwtg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [TOTAL_W-1:0]   rem_init,
    input  logic [DIV_Q_W-1:0]   low_init,
    input  logic [TOTAL_W-1:0]   den,
    input  logic [DIV_CNT_W-1:0] iters,
    output logic                 done,
    output logic [DIV_Q_W-1:0]   quo
);

    logic [TOTAL_W-1:0]   rem_reg;
    logic [DIV_Q_W-1:0]   low_reg;
    logic [TOTAL_W-1:0]   den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [TOTAL_W+1:0]   diff;

    // One restoring step: shift in the next dividend bit and try to subtract.
    assign diff = {1'b0, rem_reg, low_reg[DIV_Q_W-1]} - {2'b00, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == DIV_CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= iters;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= rem_init;
            low_reg <= low_init;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            if (!diff[TOTAL_W+1])
            begin
                rem_reg <= diff[TOTAL_W-1:0];
                low_reg <= {low_reg[DIV_Q_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[TOTAL_W-2:0], low_reg[DIV_Q_W-1]};
                low_reg <= {low_reg[DIV_Q_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quo  = low_reg;

endmodule

// ----- rtl/gwtg_datapath.sv -----
module gwtg_datapath
    import gwtg_pkg::*;
#(
    parameter int TAPS = TAPS_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  gwtg_cmd_t           cmd,
    output gwtg_status_t        status,
    input  logic [SIGMA_W-1:0]  sigma_q8,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [WEIGHT_W-1:0] weight_q16,
    output logic [TAP_W-1:0]    tap_index,
    output logic                last_tap,
    output logic                rejected
);

    localparam int IDX_W = (TAPS > 1) ? $clog2(TAPS) : 1;

    logic [SIGMA_W-1:0]  sigma_reg;
    logic [FRAC_W-1:0]   f_reg;
    logic [NINT_W-1:0]   n_reg;
    logic [RAW_W-1:0]    t_reg;
    logic [V_W-1:0]      v_reg;
    logic [V_W-1:0]      q0_reg;
    logic [TOTAL_W-1:0]  total_reg;
    logic [RAW_W-1:0]    rd_reg;
    logic [RAW_W-1:0]    raw_mem [TAPS];

    logic                out_valid_reg;
    logic [WEIGHT_W-1:0] weight_reg;
    logic [TAP_W-1:0]    tap_idx_reg;
    logic                last_reg;
    logic                rej_reg;

    logic [XX_W-1:0]          xx;
    logic [SIGMA_W-1:0]       xx4;
    logic                     a_big;
    logic [FRAC_W+RAW_W-1:0]  fv_prod;
    logic [V_W+RAW_W-1:0]     rc_prod;
    logic [V_W+K_W-1:0]       qk;
    logic [V_W+K_W-1:0]       r_fix;
    logic [V_W-1:0]           q_fix;
    logic [2*RAW_W-1:0]       e_prod;

    logic                 div_start;
    logic [TOTAL_W-1:0]   div_rem_init;
    logic [DIV_Q_W-1:0]   div_low_init;
    logic [TOTAL_W-1:0]   div_den;
    logic [DIV_CNT_W-1:0] div_iters;
    logic                 div_done;
    logic [DIV_Q_W-1:0]   div_quo;

    // A tap whose argument reaches 32 in its integer part has a zero weight;
    // that happens exactly when 4*x*x >= sigma.
    assign xx    = XX_W'(cmd.tap) * XX_W'(cmd.tap);
    assign xx4   = SIGMA_W'({xx, 2'b00});
    assign a_big = (xx4 >= sigma_reg);

    assign fv_prod = FRAC_W'(f_reg) * t_reg;
    assign rc_prod = v_reg * recip_q32(cmd.k);
    assign qk      = (V_W+K_W)'(q0_reg) * (V_W+K_W)'(cmd.k);
    assign r_fix   = (V_W+K_W)'(v_reg) - qk;
    assign q_fix   = q0_reg + V_W'(r_fix >= (V_W+K_W)'(cmd.k));
    assign e_prod  = (2*RAW_W)'(t_reg) * (2*RAW_W)'(EXP_M1_Q31);

    always_comb
    begin
        div_start    = (cmd.a_start && !a_big) || cmd.n_start;
        div_rem_init = TOTAL_W'({xx, 2'b00});
        div_low_init = '0;
        div_den      = TOTAL_W'(sigma_reg);
        div_iters    = A_DIV_ITERS;
        if (cmd.n_start)
        begin
            // Dividend is raw << 16; its quotient stays below 2^17.
            div_rem_init = TOTAL_W'(rd_reg[RAW_W-1:1]);
            div_low_init = {rd_reg[0], {(DIV_Q_W-1){1'b0}}};
            div_den      = total_reg;
            div_iters    = N_DIV_ITERS;
        end
    end

    gwtg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .rem_init (div_rem_init),
        .low_init (div_low_init),
        .den      (div_den),
        .iters    (div_iters),
        .done     (div_done),
        .quo      (div_quo)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load_sigma)
            sigma_reg <= sigma_q8;

        if (cmd.a_start && a_big)
        begin
            t_reg <= '0;
            n_reg <= '0;
        end
        else if (cmd.a_take)
        begin
            f_reg <= div_quo[FRAC_W-1:0];
            n_reg <= div_quo[FRAC_W+NINT_W-1:FRAC_W];
            t_reg <= ONE_Q31;
        end
        else if (cmd.h_fix)
            t_reg <= ONE_Q31 - RAW_W'(q_fix);
        else if (cmd.e_mul)
        begin
            t_reg <= RAW_W'(e_prod[2*RAW_W-1:RAW_W-1]);
            n_reg <= n_reg - NINT_W'(1);
        end

        if (cmd.h_mul)
            v_reg <= fv_prod[FRAC_W+V_W-1:FRAC_W];
        if (cmd.h_rcp)
            q0_reg <= rc_prod[V_W+RAW_W-1:RAW_W];

        if (cmd.store)
            raw_mem[cmd.tap[IDX_W-1:0]] <= t_reg;
        if (cmd.mem_rd)
            rd_reg <= raw_mem[cmd.tap[IDX_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            total_reg <= '0;
        else if (cmd.load_sigma)
            total_reg <= '0;
        else if (cmd.store)
            total_reg <= total_reg + TOTAL_W'({t_reg, 1'b0});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_tap || cmd.out_rej)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_tap)
        begin
            weight_reg  <= div_quo[WEIGHT_W-1:0];
            tap_idx_reg <= cmd.tap;
            last_reg    <= (cmd.tap == TAP_W'(TAPS - 1));
            rej_reg     <= 1'b0;
        end
        else if (cmd.out_rej)
        begin
            weight_reg  <= '0;
            tap_idx_reg <= '0;
            last_reg    <= 1'b1;
            rej_reg     <= 1'b1;
        end
    end

    assign status.sigma_zero = (sigma_q8 == '0);
    assign status.a_big      = a_big;
    assign status.div_done   = div_done;
    assign status.n_zero     = (n_reg == '0);
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign weight_q16 = weight_reg;
    assign tap_index  = tap_idx_reg;
    assign last_tap   = last_reg;
    assign rejected   = rej_reg;

endmodule

// ----- rtl/gwtg_ctrl.sv -----
module gwtg_ctrl
    import gwtg_pkg::*;
#(
    parameter int TAPS = TAPS_DEFAULT
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  gwtg_status_t status,
    output gwtg_cmd_t    cmd
);

    gwtg_state_t      state_reg, state_next;
    logic [TAP_W-1:0] tap_reg, tap_next;
    logic [K_W-1:0]   k_reg, k_next;
    logic             last;

    assign last = (tap_reg == TAP_W'(TAPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            tap_reg   <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            tap_reg   <= tap_next;
            k_reg     <= k_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        tap_next   = tap_reg;
        k_next     = k_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    tap_next   = '0;
                    state_next = status.sigma_zero ? ST_REJECT : ST_TAP_START;
                end
            end
            ST_REJECT:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            ST_TAP_START:
                state_next = status.a_big ? ST_STORE : ST_ADIV;
            ST_ADIV:
            begin
                if (status.div_done)
                begin
                    k_next     = HORNER_TERMS;
                    state_next = ST_H_MUL;
                end
            end
            ST_H_MUL:
                state_next = ST_H_RCP;
            ST_H_RCP:
                state_next = ST_H_FIX;
            ST_H_FIX:
            begin
                if (k_reg == K_W'(1))
                    state_next = ST_E_MUL;
                else
                begin
                    k_next     = k_reg - K_W'(1);
                    state_next = ST_H_MUL;
                end
            end
            ST_E_MUL:
            begin
                if (status.n_zero)
                    state_next = ST_STORE;
            end
            ST_STORE:
            begin
                if (last)
                begin
                    tap_next   = '0;
                    state_next = ST_N_READ;
                end
                else
                begin
                    tap_next   = tap_reg + TAP_W'(1);
                    state_next = ST_TAP_START;
                end
            end
            ST_N_READ:
                state_next = ST_N_START;
            ST_N_START:
                state_next = ST_N_DIV;
            ST_N_DIV:
            begin
                if (status.div_done)
                    state_next = ST_N_OUT;
            end
            ST_N_OUT:
            begin
                if (status.out_free)
                begin
                    if (last)
                        state_next = ST_IDLE;
                    else
                    begin
                        tap_next   = tap_reg + TAP_W'(1);
                        state_next = ST_N_READ;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.tap  = tap_reg;
        cmd.k    = k_reg;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready       = 1'b1;
                cmd.load_sigma = in_valid && !status.sigma_zero;
            end
            ST_REJECT:    cmd.out_rej = status.out_free;
            ST_TAP_START: cmd.a_start = 1'b1;
            ST_ADIV:      cmd.a_take  = status.div_done;
            ST_H_MUL:     cmd.h_mul   = 1'b1;
            ST_H_RCP:     cmd.h_rcp   = 1'b1;
            ST_H_FIX:     cmd.h_fix   = 1'b1;
            ST_E_MUL:     cmd.e_mul   = !status.n_zero;
            ST_STORE:     cmd.store   = 1'b1;
            ST_N_READ:    cmd.mem_rd  = 1'b1;
            ST_N_START:   cmd.n_start = 1'b1;
            ST_N_DIV:     cmd.out_tap = 1'b0;
            ST_N_OUT:     cmd.out_tap = status.out_free;
            default:      cmd.out_tap = 1'b0;
        endcase
    end

endmodule

// ----- rtl/gaussian_weight_table_generator.sv -----
// Channel   Signals                                      Direction
// ------    -------------------------------------------  ---------
// input     in_valid, in_ready, sigma_q8                 in
// output    out_valid, out_ready, weight_q16, tap_index, out
//           last_tap, rejected
//
// One input transaction is worked on at a time; in_ready is high only while
// the controller is idle. Each tap below the zero-weight cutoff runs a
// 21-step division for the argument, a 12-term Horner loop whose terms each
// pass through the multiply, reciprocal and fix-up states, and one exp(-1)
// multiplication per integer unit of its exponent argument (up to 31); a tap
// past the cutoff goes straight to storing a zero weight. Each normalized
// result then comes from the 17-step division by the weight total and waits
// for the output to be free. A zero sigma gives a single rejected result.
// Reset is asynchronous and clears all control state; there is no clearing
// pass. A stalled output holds the finished result in the output register,
// and the next input transaction can be taken while the last result of the
// previous one still waits.
module gaussian_weight_table_generator
    import gwtg_pkg::*;
#(
    parameter int TAPS = TAPS_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [SIGMA_W-1:0]  sigma_q8,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [WEIGHT_W-1:0] weight_q16,
    output logic [TAP_W-1:0]    tap_index,
    output logic                last_tap,
    output logic                rejected
);

    // The controller sequences the per-tap work; the datapath holds the
    // argument and normalization divider, the Horner and exp(-1) multipliers, the raw weight
    // memory, the running total and the output register.
    gwtg_cmd_t    cmd;
    gwtg_status_t status;

    gwtg_ctrl #(
        .TAPS (TAPS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    gwtg_datapath #(
        .TAPS (TAPS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .sigma_q8   (sigma_q8),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .weight_q16 (weight_q16),
        .tap_index  (tap_index),
        .last_tap   (last_tap),
        .rejected   (rejected)
    );

`ifndef ASSERT_OFF
    // A rejected transaction carries no weight and closes its item at once.
    a_reject_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rejected |-> weight_q16 == '0 && last_tap && tap_index == '0)
        else $error("rejected result has a weight or is not marked last");

    // A normalized weight is at most one half: every tap counts twice in the total.
    a_weight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !rejected |-> weight_q16 <= 16'h8000)
        else $error("normalized weight above one half");

    // On a normalized result the last mark sits on the final tap and nowhere else.
    a_last_tap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !rejected |-> last_tap == (tap_index == TAP_W'(TAPS - 1)))
        else $error("last mark does not match the final tap");

    // No new input is taken while a tap is still being computed.
    a_idle_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("controller stayed idle after taking an input");
`endif

endmodule
